// File: rtl/core/sipq_pkg.sv
// sipq_pkg: types and codes shared by the sorted-insert priority queue
// holds the request/response beat structs, cell entry and cell control types
// no dependencies
package sipq_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 32;
   localparam int TAG_BITS   = 16;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   // request mode codes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;

   typedef struct packed {
      logic                       mode;
      logic signed [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0]        tag;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic signed [KEY_BITS-1:0] popped_key;
      logic [TAG_BITS-1:0]        popped_tag;
      logic [COUNT_BITS-1:0]      count;
      logic                       empty_res;
   } rsp_type;

   // one stored slot of the sorted chain
   typedef struct packed {
      logic                       valid;
      logic signed [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0]        tag;
   } entry_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic                       ins;
      logic                       pop;
      logic signed [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0]        tag;
   } cell_ctrl_type;

endpackage

// File: rtl/core/sipq_cell.sv
// sipq_cell: one compare-and-shift slot of the sorted chain
// depends on sipq_pkg (entry_type, cell_ctrl_type)
module sipq_cell
   import sipq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     prev_entry,
   input  logic          prev_place,
   input  entry_type     next_entry,
   output entry_type     entry,
   output logic          place
);

   logic                       valid_ff, valid_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0]        tag_ff, tag_in;

   // new key belongs at or before this slot (empty slots count as larger)
   assign place = !valid_ff || (ctrl.key <= key_ff);

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.tag   = tag_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      if (ctrl.ins) begin
         if (prev_place) begin
            valid_in = prev_entry.valid;
            key_in   = prev_entry.key;
            tag_in   = prev_entry.tag;
         end else if (place) begin
            valid_in = 1'b1;
            key_in   = ctrl.key;
            tag_in   = ctrl.tag;
         end
      end else if (ctrl.pop) begin
         valid_in = next_entry.valid;
         key_in   = next_entry.key;
         tag_in   = next_entry.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

// File: rtl/core/sorted_insert_priority_queue.sv
// sorted_insert_priority_queue: bounded priority queue as a chain of sorted cells
// depends on sipq_pkg and sipq_cell
//
//   channel   ports                          beat        direction
//   request   req_valid req_stall req_data   req_type    in
//   response  rsp_valid rsp_stall rsp_data   rsp_type    out
//
// one request per cycle while req_stall is low: every cell compares the broadcast
// key and shifts in the same cycle, and the response appears in the output
// register on the next cycle
// reset empties the chain by clearing each cell's valid bit
// a response held by rsp_stall stalls new requests only while it still waits
module sorted_insert_priority_queue
   import sipq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W = COUNT_BITS;

   logic             accept;
   logic             is_full, is_empty;
   logic             do_ins, do_pop;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   cell_ctrl_type    ctrl;

   entry_type           ent [CAPACITY];
   logic [CAPACITY-1:0] place;
   logic [CAPACITY-1:0] valid_vec;

   // take a beat unless an untaken response sits in the output register
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // full insert and empty pop leave the chain untouched
   assign do_ins = accept && (req_data.mode == MODE_INSERT) && !is_full;
   assign do_pop = accept && (req_data.mode == MODE_POP) && !is_empty;

   assign ctrl.ins = do_ins;
   assign ctrl.pop = do_pop;
   assign ctrl.key = req_data.key;
   assign ctrl.tag = req_data.tag;

   // the chain: slot 0 holds the smallest key
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_p;

      if (i == 0) begin : g_head
         assign prev_e = '0;
         assign prev_p = 1'b0;
      end else begin : g_body
         assign prev_e = ent[i-1];
         assign prev_p = place[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_e = '0;
      end else begin : g_link
         assign next_e = ent[i+1];
      end

      sipq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_entry (prev_e),
         .prev_place (prev_p),
         .next_entry (next_e),
         .entry      (ent[i]),
         .place      (place[i])
      );

      assign valid_vec[i] = ent[i].valid;
   end

   // entry count after this beat
   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // response beat built from the pre-update front slot and new count
   always_comb begin
      rsp_in.status     = STATUS_DONE;
      rsp_in.popped_key = '0;
      rsp_in.popped_tag = '0;
      if (req_data.mode == MODE_INSERT) begin
         if (is_full) begin
            rsp_in.status = STATUS_FULL;
         end
      end else begin
         if (is_empty) begin
            rsp_in.status = STATUS_EMPTY;
         end else begin
            rsp_in.popped_key = ent[0].key;
            rsp_in.popped_tag = ent[0].tag;
         end
      end
      rsp_in.count     = COUNT_BITS'(count_in);
      rsp_in.empty_res = (count_in == '0);
   end

   // output register: loads on accept, holds while stalled
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // occupied slots form a contiguous run from slot 0
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + {{(CAPACITY-1){1'b0}}, 1'b1}) & valid_vec) == '0)
      else $error("occupied slots not contiguous from the front");

   // counter tracks the number of occupied slots
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("entry count disagrees with occupied slots");

   // a pop of a nonempty queue removes exactly one entry
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not remove one entry");

   // neighboring occupied slots stay in nondecreasing key order
   for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_order_chk
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         (ent[j].valid && ent[j+1].valid) |-> (ent[j].key <= ent[j+1].key))
         else $error("chain out of key order");
   end
`endif

endmodule
